// ----- rtl/varint_size_decoder_macros.svh -----
// Assertion macros used by the decoder RTL (vsd_decode).
`ifndef VARINT_SIZE_DECODER_MACROS_SVH
`define VARINT_SIZE_DECODER_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define VSD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define VSD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/vsd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vsd_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = 4;
  localparam int unsigned ChunkWidth = 7;

  localparam int unsigned ContBit = 7;
  localparam logic [ChunkWidth-1:0] LastLimit = 7'h10;
  localparam logic [CountWidth-1:0] CountMax = 4'd15;
  localparam logic [CountWidth-1:0] FullChunks = 4'd4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } byte_item_t;

  // Place a 7-bit chunk at its position in the value; the fifth chunk keeps 4 bits.
  function automatic logic [ValueWidth-1:0] place_chunk(
    input logic [ChunkWidth-1:0] payload,
    input logic [CountWidth-1:0] idx
  );
    logic [ValueWidth-1:0] res;
    res = '0;
    case (idx)
      4'd0:    res = {25'b0, payload};
      4'd1:    res = {18'b0, payload, 7'b0};
      4'd2:    res = {11'b0, payload, 14'b0};
      4'd3:    res = {4'b0, payload, 21'b0};
      4'd4:    res = {payload[3:0], 28'b0};
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/vsd_byte_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface vsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

// ----- rtl/vsd_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface vsd_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [3:0]  byte_count;
  logic [1:0]  status;

  modport source (output valid, output value, output byte_count, output status,
                  input ready);
  modport sink (input valid, input value, input byte_count, input status,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/vsd_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vsd_in_stage
  import vsd_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  vsd_byte_if.sink      in_i,
  vsd_byte_if.source    out_o
);

  logic       valid_q, valid_d;
  byte_item_t item_q;

  // Take a new item whenever the register is empty or draining.
  assign in_i.ready = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload on accept.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.data_byte     <= in_i.data_byte;
      item_q.end_of_buffer <= in_i.end_of_buffer;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.data_byte     = item_q.data_byte;
  assign out_o.end_of_buffer = item_q.end_of_buffer;

endmodule

`default_nettype wire

// ----- rtl/vsd_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "varint_size_decoder_macros.svh"

module vsd_decode
  import vsd_pkg::*;
(
  input  wire            clk_i,
  input  wire            rst_ni,
  vsd_byte_if.sink       in_i,
  vsd_result_if.source   out_o
);

  logic [ValueWidth-1:0] acc_q, acc_d;
  logic [CountWidth-1:0] seen_q, seen_d;
  logic                  ovf_q, ovf_d;

  logic                  out_valid_q, out_valid_d;
  logic [ValueWidth-1:0] value_q, value_d;
  logic [CountWidth-1:0] count_q;
  status_e               status_q, status_d;

  logic                  cont;
  logic [ChunkWidth-1:0] payload;
  logic [CountWidth-1:0] count;
  logic                  emit;
  logic                  out_free;
  logic                  fire;
  logic                  bad;
  logic [ValueWidth-1:0] chunk;

  // Split the byte and bump the saturating count.
  assign cont     = in_i.data_byte[ContBit];
  assign payload  = in_i.data_byte[ChunkWidth-1:0];
  assign count    = (seen_q < CountMax) ? seen_q + 4'd1 : CountMax;
  assign emit     = !cont || in_i.end_of_buffer;
  assign out_free = !out_valid_q || out_o.ready;
  assign fire     = in_i.valid && (!emit || out_free);
  assign chunk    = place_chunk(payload, seen_q);

  // Stall only a byte that ends a number while the result register is full.
  assign in_i.ready = !emit || out_free;

  // Result of a byte that ends a number.
  always_comb begin
    bad      = ovf_q || (seen_q > FullChunks) ||
               ((seen_q == FullChunks) && (payload >= LastLimit));
    value_d  = '0;
    status_d = ST_OK;
    if (cont) begin
      status_d = ST_TRUNCATED;
    end else if (bad) begin
      status_d = ST_OVERFLOW;
    end else begin
      value_d = acc_q | chunk;
    end
  end

  // Advance the number state; clear it after each result.
  always_comb begin
    acc_d  = acc_q;
    seen_d = seen_q;
    ovf_d  = ovf_q;
    if (fire) begin
      if (emit) begin
        acc_d  = '0;
        seen_d = '0;
        ovf_d  = 1'b0;
      end else begin
        if (seen_q < FullChunks) begin
          acc_d = acc_q | chunk;
        end else begin
          ovf_d = 1'b1;
        end
        seen_d = count;
      end
    end
  end

  // Hold the result until taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (fire && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      seen_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      seen_q      <= seen_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      value_q  <= value_d;
      count_q  <= count;
      status_q <= status_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.value      = value_q;
  assign out_o.byte_count = count_q;
  assign out_o.status     = status_q;

  `VSD_ASSERT(a_err_zero, (out_valid_q && status_q != ST_OK) |-> (value_q == '0), "error result carries a nonzero value")
  `VSD_ASSERT(a_ok_short, (out_valid_q && status_q == ST_OK) |-> (count_q <= 4'd5), "good result longer than five bytes")
  `VSD_ASSERT(a_clear_after, (fire && emit) |=> (seen_q == '0 && acc_q == '0 && !ovf_q), "state not cleared after result")
  `VSD_ASSERT(a_empty_acc, (seen_q == '0) |-> (acc_q == '0 && !ovf_q), "stale bits with no bytes seen")
  `VSD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_q || rst_ni, "result valid out of reset")

endmodule

`default_nettype wire

// ----- rtl/varint_size_decoder.sv -----
// Path: a result is valid once the byte that ends its number has been accepted and has passed
// the input register, then the result register.
// Throughput: 1 byte per cycle; a byte that ends a number waits only while the previous
// result is held by a stalled receiver. The decode between the registers is a chunk
// placement, an OR and a few compares.
// Reset: rst_ni clears the accumulator, byte count, overflow flag and both valid bits.
`timescale 1ns / 1ps
`default_nettype none

module varint_size_decoder
  import vsd_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  vsd_byte_if.sink      in_i,
  vsd_result_if.source  out_o
);

  vsd_byte_if staged ();

  vsd_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (staged.source)
  );

  vsd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (staged.sink),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
